[hw/rtl/crc8f_pkg.sv]
package crc8f_pkg;

    localparam int REPORT_BYTES_DEF = 64;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [7:0] PREFIX_BYTE = 8'h3f;
    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [4:0] SEQ_MAX     = 5'd31;
    localparam logic [4:0] SEQ_FIRST   = 5'd1;

    localparam int IN_DATA_W = 24;

    typedef enum logic [1:0] {
        FUNC_BEGIN   = 2'd0,
        FUNC_PAYLOAD = 2'd1,
        FUNC_END     = 2'd2
    } func_t;

    // One queued job: for begin, data is the header byte; for payload, the byte itself.
    typedef struct packed {
        func_t      kind;
        logic [7:0] data;
        logic [7:0] command;
    } job_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[hw/rtl/crc8_command_report_framer.sv]
// Channel    Dir  Beat                   tdata / tuser / tlast
// s_axis     in   one command            tdata: feature, command, payload_byte; tuser: func
// m_axis     out  one report byte        tdata: report_byte, byte_index; tlast: last
//
// A payload beat yields one output byte per cycle while m_axis is ready; a begin yields
// four bytes and an end yields zero padding up to REPORT_BYTES and then the CRC byte, set by the back-end sequencer.
// Stray items, overflow payload and func 3 are dropped at the front.
// A 4-deep job queue sits between front and back; each stalls independently.
// rst_n is asynchronous and clears all control state; no clearing pass.
module crc8_command_report_framer
    import crc8f_pkg::*;
#(
    parameter int REPORT_BYTES = REPORT_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,  // feature[2:0], command[10:3], payload_byte[18:11]
    input  logic [1:0]           s_axis_tuser,  // func[1:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [((8 + $clog2(REPORT_BYTES + 1) + 7) / 8) * 8 - 1:0]
                                 m_axis_tdata,  // report_byte, then byte_index
    output logic                 m_axis_tlast   // last
);

    localparam int IDX_W  = $clog2(REPORT_BYTES + 1);
    localparam int OUT_W  = ((8 + IDX_W + 7) / 8) * 8;

    logic             push, pop, full, head_valid;
    job_t             push_job, head_job;
    logic [7:0]       out_byte;
    logic [IDX_W-1:0] out_index;

    crc8f_front #(.REPORT_BYTES(REPORT_BYTES)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_func    (s_axis_tuser),
        .in_feature (s_axis_tdata[2:0]),
        .in_command (s_axis_tdata[10:3]),
        .in_payload (s_axis_tdata[18:11]),
        .queue_full (full),
        .in_ready   (s_axis_tready),
        .push       (push),
        .push_job   (push_job)
    );

    crc8f_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    crc8f_back #(.REPORT_BYTES(REPORT_BYTES)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_byte   (out_byte),
        .out_index  (out_index),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({out_index, out_byte});

endmodule

[hw/rtl/crc8f_front.sv]
module crc8f_front
    import crc8f_pkg::*;
#(
    parameter int REPORT_BYTES = REPORT_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           in_func,
    input  logic [2:0]           in_feature,
    input  logic [7:0]           in_command,
    input  logic [7:0]           in_payload,
    input  logic                 queue_full,
    output logic                 in_ready,
    output logic                 push,
    output job_t                 push_job
);

    localparam int PAY_MAX = REPORT_BYTES - 4;
    localparam int CNT_W   = $clog2(PAY_MAX + 1);

    logic [4:0]       seq_reg, seq_next;
    logic             open_reg, open_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic [4:0]       seq_inc;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign seq_inc  = (seq_reg == SEQ_MAX) ? SEQ_FIRST : seq_reg + 5'd1;

    // Shadow of the frame state, tracked in accept order so the back end
    // only ever sees jobs that produce output.
    always_comb
    begin
        seq_next      = seq_reg;
        open_next     = open_reg;
        cnt_next      = cnt_reg;
        push          = 1'b0;
        push_job.kind    = FUNC_BEGIN;
        push_job.data    = in_payload;
        push_job.command = in_command;
        if (accept)
        begin
            case (in_func)
                FUNC_BEGIN:
                begin
                    seq_next      = seq_inc;
                    open_next     = 1'b1;
                    cnt_next      = '0;
                    push          = 1'b1;
                    push_job.kind = FUNC_BEGIN;
                    push_job.data = {seq_inc, in_feature};
                end
                FUNC_PAYLOAD:
                begin
                    if (open_reg && (cnt_reg < CNT_W'(PAY_MAX)))
                    begin
                        cnt_next      = cnt_reg + CNT_W'(1);
                        push          = 1'b1;
                        push_job.kind = FUNC_PAYLOAD;
                    end
                end
                FUNC_END:
                begin
                    if (open_reg)
                    begin
                        open_next     = 1'b0;
                        push          = 1'b1;
                        push_job.kind = FUNC_END;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg  <= '0;
            open_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            seq_reg  <= seq_next;
            open_reg <= open_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

[hw/rtl/crc8f_queue.sv]
module crc8f_queue
    import crc8f_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full       = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = mem[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        if (do_pop)
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[hw/rtl/crc8f_back.sv]
module crc8f_back
    import crc8f_pkg::*;
#(
    parameter int REPORT_BYTES = REPORT_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                head_valid,
    input  job_t                                head_job,
    output logic                                pop,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [7:0]                          out_byte,
    output logic [$clog2(REPORT_BYTES + 1)-1:0] out_index,
    output logic                                out_last
);

    localparam int IDX_W = $clog2(REPORT_BYTES + 1);

    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [7:0]       crc_reg, crc_next;
    logic [1:0]       step_reg, step_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic [IDX_W-1:0] index_reg, index_next;
    logic             last_reg, last_next;
    logic             advance, emit;
    logic [7:0]       crc_upd;
    logic [7:0]       cur_byte;

    assign advance = !valid_reg || out_ready;
    assign emit    = head_valid && advance;
    assign crc_upd = crc8_byte(crc_reg, cur_byte);

    // Byte that the head job puts out at this beat, before the CRC step.
    always_comb
    begin
        case (head_job.kind)
            FUNC_BEGIN:
            begin
                case (step_reg)
                    2'd0:    cur_byte = 8'h00;
                    2'd1:    cur_byte = PREFIX_BYTE;
                    2'd2:    cur_byte = head_job.data;
                    default: cur_byte = head_job.command;
                endcase
            end
            FUNC_PAYLOAD: cur_byte = head_job.data;
            default:      cur_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        step_next  = step_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        index_next = index_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (advance)
            valid_next = 1'b0;
        if (emit)
        begin
            valid_next = 1'b1;
            byte_next  = cur_byte;
            last_next  = 1'b0;
            case (head_job.kind)
                FUNC_BEGIN:
                begin
                    index_next = IDX_W'(step_reg);
                    pos_next   = IDX_W'(step_reg) + IDX_W'(1);
                    // the leading zero byte and prefix stay out of the CRC
                    crc_next   = step_reg[1] ? crc_upd : 8'h00;
                    step_next  = step_reg + 2'd1;
                    pop        = (step_reg == 2'd3);
                end
                FUNC_PAYLOAD:
                begin
                    index_next = pos_reg;
                    pos_next   = pos_reg + IDX_W'(1);
                    crc_next   = crc_upd;
                    pop        = 1'b1;
                end
                default:
                begin
                    if (pos_reg < IDX_W'(REPORT_BYTES))
                    begin
                        index_next = pos_reg;
                        pos_next   = pos_reg + IDX_W'(1);
                        crc_next   = crc_upd;
                    end
                    else
                    begin
                        byte_next  = crc_reg;
                        index_next = IDX_W'(REPORT_BYTES);
                        last_next  = 1'b1;
                        pos_next   = '0;
                        crc_next   = 8'h00;
                        pop        = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            crc_reg   <= '0;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        index_reg <= index_next;
        last_reg  <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_index = index_reg;
    assign out_last  = last_reg;

endmodule
